### sv/deqs_pkg.sv
// Shared constants, codes and types for the double-ended queue with search.
package deqs_pkg;

  localparam int CAPACITY     = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int ACTION_W     = 4;
  localparam int STATUS_W     = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_FRONT  = 4'd0,
    ACT_ADD_BACK   = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_PEEK_FRONT = 4'd4,
    ACT_PEEK_BACK  = 4'd5,
    ACT_REMOVE     = 4'd6,
    ACT_FIND       = 4'd7,
    ACT_DUMP       = 4'd8
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_SHR  = 3'd1,
    OP_SHL  = 3'd2,
    OP_PUT  = 3'd3,
    OP_ROT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    cnt_t     count;
    word_t    item;
  } cell_ctl_t;

endpackage

### sv/deqs_cell.sv
// One storage cell of the chain: holds a word and on command takes a neighbour's word, the new item or the head word.
module deqs_cell (
  input  logic                 clk,
  input  deqs_pkg::cell_ctl_t  ctl,
  input  deqs_pkg::idx_t       idx,
  input  deqs_pkg::word_t      left_word,
  input  deqs_pkg::word_t      right_word,
  input  deqs_pkg::word_t      head_word,
  output deqs_pkg::word_t      word,
  output deqs_pkg::word_t      tail_word
);

  deqs_pkg::word_t word_r;
  deqs_pkg::word_t word_nxt;
  deqs_pkg::cnt_t  pos;
  logic            is_tail;
  logic            in_body;

  // locate this cell against the held region
  assign pos     = deqs_pkg::cnt_t'(idx);
  assign is_tail = (pos + deqs_pkg::cnt_t'(1)) == ctl.count;
  assign in_body = (pos + deqs_pkg::cnt_t'(1)) < ctl.count;

  // select the next word
  always_comb begin
    word_nxt = word_r;
    unique case (ctl.op)
      deqs_pkg::OP_HOLD: word_nxt = word_r;
      deqs_pkg::OP_SHR:  word_nxt = left_word;
      deqs_pkg::OP_SHL:  word_nxt = right_word;
      deqs_pkg::OP_PUT:  word_nxt = (pos == ctl.count) ? ctl.item : word_r;
      deqs_pkg::OP_ROT: begin
        if (is_tail) begin
          word_nxt = head_word;
        end else if (in_body) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  // hold the word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word      = word_r;
  assign tail_word = is_tail ? word_r : '0;

endmodule

### sv/double_ended_queue_with_search_core.sv
// Latency: push, pop, peek and unused codes give one result in the cycle after acceptance.
// Throughput: those take one item per cycle; find, remove and dump hold busy while the chain
// of cells rotates once through its held region.
// Dump gives one result per cycle of that rotation; find and remove give theirs at its end.
// Reset (rst_n low, synchronous) empties the store and returns to idle; words are not cleared.
// Results cannot be stalled: each is shown for one cycle under out_valid.
module double_ended_queue_with_search_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_action,
  input  logic [31:0] in_item,
  output logic        out_valid,
  output logic [31:0] out_data,
  output logic [1:0]  out_status,
  output logic [6:0]  out_count,
  output logic        out_last
);

  deqs_pkg::state_t    state_r, state_nxt;
  deqs_pkg::cnt_t      count_r, count_nxt;
  deqs_pkg::cnt_t      step_r, step_nxt;
  deqs_pkg::word_t     key_r, key_nxt;
  logic                found_r, found_nxt;
  deqs_pkg::word_t     found_word_r, found_word_nxt;
  deqs_pkg::action_t   walk_op_r, walk_op_nxt;
  logic                out_valid_r, out_valid_nxt;
  deqs_pkg::word_t     out_word_r, out_word_nxt;
  deqs_pkg::status_t   out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  deqs_pkg::cell_ctl_t ctl;
  deqs_pkg::cell_op_t  op;
  deqs_pkg::action_t   act;
  deqs_pkg::word_t     item_word;
  deqs_pkg::word_t     cell_word [deqs_pkg::CAPACITY];
  deqs_pkg::word_t     cell_tail [deqs_pkg::CAPACITY];
  deqs_pkg::word_t     head_word;
  deqs_pkg::word_t     tail_word;
  logic                accept;
  logic                full;
  logic                empty;
  logic                hit;
  logic                final_step;

  assign act        = deqs_pkg::action_t'(in_action);
  assign item_word  = deqs_pkg::word_t'(in_item);
  assign accept     = start && (state_r == deqs_pkg::S_IDLE);
  assign full       = count_r == deqs_pkg::cnt_t'(deqs_pkg::CAPACITY);
  assign empty      = count_r == '0;
  assign head_word  = cell_word[0];
  assign hit        = !found_r && (head_word == key_r);
  assign final_step = step_r == deqs_pkg::cnt_t'(1);

  // build the chain of cells
  assign ctl.op    = op;
  assign ctl.count = count_r;
  assign ctl.item  = item_word;

  for (genvar i = 0; i < deqs_pkg::CAPACITY; i++) begin : g_cell
    deqs_pkg::word_t left_w;
    deqs_pkg::word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = item_word;
    end else begin : g_inner_l
      assign left_w = cell_word[i-1];
    end
    if (i == deqs_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_word[i+1];
    end
    deqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (deqs_pkg::idx_t'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (head_word),
      .word       (cell_word[i]),
      .tail_word  (cell_tail[i])
    );
  end

  // gather the back word: only the tail cell drives a non-zero value
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < deqs_pkg::CAPACITY; i++) begin
      tail_word = tail_word | cell_tail[i];
    end
  end

  // next state, chain command and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    found_word_nxt = found_word_r;
    walk_op_nxt    = walk_op_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = '0;
    out_status_nxt = deqs_pkg::STAT_OK;
    out_last_nxt   = 1'b1;
    op             = deqs_pkg::OP_HOLD;

    unique case (state_r)
      deqs_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (act) inside
            deqs_pkg::ACT_ADD_FRONT, deqs_pkg::ACT_ADD_BACK: begin
              if (full) begin
                out_status_nxt = deqs_pkg::STAT_FULL;
              end else begin
                op        = (act == deqs_pkg::ACT_ADD_FRONT) ? deqs_pkg::OP_SHR
                                                             : deqs_pkg::OP_PUT;
                count_nxt = count_r + deqs_pkg::cnt_t'(1);
              end
            end
            deqs_pkg::ACT_POP_FRONT, deqs_pkg::ACT_POP_BACK,
            deqs_pkg::ACT_PEEK_FRONT, deqs_pkg::ACT_PEEK_BACK,
            deqs_pkg::ACT_REMOVE, deqs_pkg::ACT_FIND, deqs_pkg::ACT_DUMP: begin
              if (empty) begin
                out_status_nxt = deqs_pkg::STAT_EMPTY;
              end else begin
                unique case (act) inside
                  deqs_pkg::ACT_POP_FRONT: begin
                    op           = deqs_pkg::OP_SHL;
                    count_nxt    = count_r - deqs_pkg::cnt_t'(1);
                    out_word_nxt = head_word;
                  end
                  deqs_pkg::ACT_POP_BACK: begin
                    count_nxt    = count_r - deqs_pkg::cnt_t'(1);
                    out_word_nxt = tail_word;
                  end
                  deqs_pkg::ACT_PEEK_FRONT: out_word_nxt = head_word;
                  deqs_pkg::ACT_PEEK_BACK:  out_word_nxt = tail_word;
                  default: begin
                    // start a rotation walk over the held words
                    out_valid_nxt = 1'b0;
                    state_nxt     = deqs_pkg::S_WALK;
                    step_nxt      = count_r;
                    key_nxt       = item_word;
                    found_nxt     = 1'b0;
                    walk_op_nxt   = act;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end

      deqs_pkg::S_WALK: begin
        step_nxt = step_r - deqs_pkg::cnt_t'(1);
        if (final_step) begin
          state_nxt = deqs_pkg::S_IDLE;
        end
        unique case (walk_op_r) inside
          deqs_pkg::ACT_REMOVE: begin
            // drop the first matching head word, rotate the rest
            if (hit) begin
              op        = deqs_pkg::OP_SHL;
              count_nxt = count_r - deqs_pkg::cnt_t'(1);
              found_nxt = 1'b1;
            end else begin
              op = deqs_pkg::OP_ROT;
            end
            out_valid_nxt  = final_step;
            out_status_nxt = (found_r || hit) ? deqs_pkg::STAT_OK : deqs_pkg::STAT_NOMATCH;
          end
          deqs_pkg::ACT_FIND: begin
            op = deqs_pkg::OP_ROT;
            if (hit) begin
              found_nxt      = 1'b1;
              found_word_nxt = head_word;
            end
            out_valid_nxt  = final_step;
            out_status_nxt = (found_r || hit) ? deqs_pkg::STAT_OK : deqs_pkg::STAT_NOMATCH;
            out_word_nxt   = found_r ? found_word_r : (hit ? head_word : '0);
          end
          default: begin
            // dump: show each head word as it passes
            op            = deqs_pkg::OP_ROT;
            out_valid_nxt = 1'b1;
            out_word_nxt  = head_word;
            out_last_nxt  = final_step;
          end
        endcase
      end

      default: state_nxt = deqs_pkg::S_IDLE;
    endcase
  end

  // hold control state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deqs_pkg::S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      walk_op_r   <= deqs_pkg::ACT_DUMP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      walk_op_r   <= walk_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    found_word_r <= found_word_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = state_r == deqs_pkg::S_WALK;
  assign out_valid  = out_valid_r;
  assign out_data   = 32'(out_word_r);
  assign out_status = out_status_r;
  assign out_count  = 7'(count_r);
  assign out_last   = out_last_r;

  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deqs_pkg::cnt_t'(deqs_pkg::CAPACITY))
    else $error("held count beyond capacity");

  // a single-step request yields one closing result in the next cycle
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action <= 4'(deqs_pkg::ACT_PEEK_BACK))
      |=> (out_valid && out_last))
    else $error("missing result for single-step request");

  // the walk ends after its final step
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == deqs_pkg::S_WALK && final_step) |=> !busy)
    else $error("walk did not end");

  // a dump run is unbroken until its closing result
  a_dump_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("open result run outside a walk");

  // full is only reported by a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == 2'(deqs_pkg::STAT_FULL))
      |-> (count_r == deqs_pkg::cnt_t'(deqs_pkg::CAPACITY)))
    else $error("full status with room left");

endmodule

### dv/double_ended_queue_with_search_core_tb.sv
// Self-checking testbench for the double-ended queue with search core.
`timescale 1ns / 1ps

module double_ended_queue_with_search_core_tb;
  import deqs_pkg::*;

  localparam int RAND_ITEMS  = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int TRACK       = 0;  // shadow of the accepted transactions
  localparam int PLAN        = 1;  // shadow used while building the stimulus
  localparam logic [ACTION_W-1:0] ACT_TOP_CODE = 4'hF;

  typedef enum int {PH_GROW, PH_MIX, PH_DRAIN} phase_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    word_t               item;
  } deq_request_t;

  typedef struct packed {
    word_t   data;
    status_t status;
    cnt_t    count;
    logic    last;
  } deq_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_action = '0;
  logic [31:0] in_item = '0;
  logic        out_valid;
  logic [31:0] out_data;
  logic [1:0]  out_status;
  logic [6:0]  out_count;
  logic        out_last;

  // Shadow deque: one copy follows the block, the other plans the stimulus
  word_t shadow_words [2][CAPACITY];
  idx_t  shadow_front [2];
  cnt_t  shadow_count [2];

  deq_request_t request_queue[$];
  deq_reply_t   awaited_replies[$];
  deq_request_t next_req;
  deq_reply_t   want;

  int  planned_count = 0;
  int  accepted_count = 0;
  int  error_count = 0;
  int  quiet_cycles = 0;
  int  reset_left = 10;
  int  gap_left = 0;
  int  burst_left = 0;
  logic took_item = 1'b0;

  double_ended_queue_with_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_action (in_action),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_status(out_status),
    .out_count (out_count),
    .out_last  (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic idx_t slot_at(int sel, int k);
    return idx_t'((int'(shadow_front[sel]) + k) % CAPACITY);
  endfunction

  // Record one reply; only the tracking shadow produces expectations
  function automatic void note_reply(int sel, word_t data, status_t status, logic last);
    deq_reply_t r;
    r.data   = data;
    r.status = status;
    r.count  = shadow_count[sel];
    r.last   = last;
    if (sel == TRACK) awaited_replies.push_back(r);
  endfunction

  // Apply one request to a shadow deque and work out its replies
  function automatic void apply_request(int sel, logic [ACTION_W-1:0] act, word_t key);
    int    n;
    int    pos;
    int    k;
    word_t w;
    n   = int'(shadow_count[sel]);
    pos = -1;
    if (act > ACT_DUMP) begin
      note_reply(sel, '0, STAT_OK, 1'b1);
    end else if (act == ACT_ADD_FRONT || act == ACT_ADD_BACK) begin
      if (n >= CAPACITY) begin
        note_reply(sel, '0, STAT_FULL, 1'b1);
      end else begin
        if (act == ACT_ADD_FRONT) begin
          shadow_front[sel] = idx_t'((int'(shadow_front[sel]) + CAPACITY - 1) % CAPACITY);
          shadow_words[sel][shadow_front[sel]] = key;
        end else begin
          shadow_words[sel][slot_at(sel, n)] = key;
        end
        shadow_count[sel] = shadow_count[sel] + cnt_t'(1);
        note_reply(sel, '0, STAT_OK, 1'b1);
      end
    end else if (n == 0) begin
      note_reply(sel, '0, STAT_EMPTY, 1'b1);
    end else begin
      // locate the first word equal to the key, front first
      for (k = 0; k < n; k++) begin
        if (pos < 0 && shadow_words[sel][slot_at(sel, k)] == key) pos = k;
      end
      case (act)
        ACT_POP_FRONT: begin
          w = shadow_words[sel][shadow_front[sel]];
          shadow_front[sel] = idx_t'((int'(shadow_front[sel]) + 1) % CAPACITY);
          shadow_count[sel] = shadow_count[sel] - cnt_t'(1);
          note_reply(sel, w, STAT_OK, 1'b1);
        end
        ACT_POP_BACK: begin
          w = shadow_words[sel][slot_at(sel, n - 1)];
          shadow_count[sel] = shadow_count[sel] - cnt_t'(1);
          note_reply(sel, w, STAT_OK, 1'b1);
        end
        ACT_PEEK_FRONT: note_reply(sel, shadow_words[sel][shadow_front[sel]], STAT_OK, 1'b1);
        ACT_PEEK_BACK:  note_reply(sel, shadow_words[sel][slot_at(sel, n - 1)], STAT_OK, 1'b1);
        ACT_REMOVE: begin
          if (pos < 0) begin
            note_reply(sel, '0, STAT_NOMATCH, 1'b1);
          end else begin
            // close the gap towards the front
            for (k = pos; k + 1 < n; k++) begin
              shadow_words[sel][slot_at(sel, k)] = shadow_words[sel][slot_at(sel, k + 1)];
            end
            shadow_count[sel] = shadow_count[sel] - cnt_t'(1);
            note_reply(sel, '0, STAT_OK, 1'b1);
          end
        end
        ACT_FIND: begin
          if (pos < 0) note_reply(sel, '0, STAT_NOMATCH, 1'b1);
          else note_reply(sel, shadow_words[sel][slot_at(sel, pos)], STAT_OK, 1'b1);
        end
        ACT_DUMP: begin
          for (k = 0; k < n; k++) begin
            note_reply(sel, shadow_words[sel][slot_at(sel, k)], STAT_OK, k == n - 1);
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Words to add: extremes, a small set that repeats, and full-range values
  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return word_t'($urandom_range(0, 7));
    return word_t'($urandom);
  endfunction

  // Keys: mostly a word held right now, otherwise anything
  function automatic word_t pick_key();
    int n;
    n = int'(shadow_count[PLAN]);
    if (n > 0 && $urandom_range(0, 99) < 65)
      return shadow_words[PLAN][slot_at(PLAN, $urandom_range(0, n - 1))];
    return rand_word();
  endfunction

  function automatic void queue_request(logic [ACTION_W-1:0] act, word_t val);
    deq_request_t q;
    q.action = act;
    q.item   = val;
    request_queue.push_back(q);
    apply_request(PLAN, act, val);
    planned_count++;
  endfunction

  function automatic logic [ACTION_W-1:0] rand_action(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 80) return $urandom_range(0, 1) ? ACT_ADD_BACK : ACT_ADD_FRONT;
        if (r < 90) return ACTION_W'($urandom_range(ACT_PEEK_FRONT, ACT_DUMP));
        return ACTION_W'($urandom_range(ACT_POP_FRONT, ACT_TOP_CODE));
      end
      PH_DRAIN: begin
        if (r < 65) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        if (r < 85) return ACT_REMOVE;
        return ACTION_W'($urandom_range(0, ACT_TOP_CODE));
      end
      default: begin
        if (r < 35) return $urandom_range(0, 1) ? ACT_ADD_BACK : ACT_ADD_FRONT;
        if (r < 55) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        return ACTION_W'($urandom_range(ACT_PEEK_FRONT, ACT_TOP_CODE));
      end
    endcase
  endfunction

  // Build the stimulus, then wait for the last reply and give the verdict
  initial begin : stimulus
    int                  rand_count;
    int                  span;
    int                  mix_len;
    int                  edge_hits;
    int                  phase_idx;
    bit                  phase_over;
    phase_t              ph;
    logic [ACTION_W-1:0] act;
    word_t               val;
    for (int s = 0; s < 2; s++) begin
      shadow_front[s] = '0;
      shadow_count[s] = '0;
    end

    // empty store: every read-type action, plus unused codes
    queue_request(ACT_POP_FRONT, '1);
    queue_request(ACT_POP_BACK, '0);
    queue_request(ACT_PEEK_FRONT, 32'h1);
    queue_request(ACT_PEEK_BACK, 32'h2);
    queue_request(ACT_REMOVE, '0);
    queue_request(ACT_FIND, '0);
    queue_request(ACT_DUMP, '1);
    queue_request(ACT_DUMP + 4'd1, 32'h5555_aaaa);
    queue_request(ACT_TOP_CODE, 32'haaaa_5555);
    // add at both ends, wrapping the front, with a repeated word
    queue_request(ACT_ADD_BACK, '1);
    queue_request(ACT_ADD_FRONT, '0);
    queue_request(ACT_ADD_BACK, 32'd5);
    queue_request(ACT_ADD_FRONT, 32'd5);
    queue_request(ACT_PEEK_FRONT, '0);
    queue_request(ACT_PEEK_BACK, '0);
    queue_request(ACT_FIND, 32'd5);
    queue_request(ACT_FIND, 32'h1234);
    queue_request(ACT_REMOVE, 32'd5);
    queue_request(ACT_REMOVE, 32'd77);
    queue_request(ACT_DUMP, '0);
    queue_request(ACT_POP_BACK, '0);
    queue_request(ACT_POP_FRONT, '0);
    queue_request(ACT_TOP_CODE - 4'd3, '1);
    queue_request(ACT_DUMP, '0);

    // random part: grow to full, mix, drain to empty, mix, and round again
    rand_count = 0;
    phase_idx  = 0;
    while (rand_count < RAND_ITEMS) begin
      case (phase_idx % 4)
        0:       ph = PH_GROW;
        2:       ph = PH_DRAIN;
        default: ph = PH_MIX;
      endcase
      span       = 0;
      edge_hits  = 0;
      mix_len    = $urandom_range(15, 40);
      phase_over = 1'b0;
      while (rand_count < RAND_ITEMS && !phase_over) begin
        act = rand_action(ph);
        if (act == ACT_ADD_FRONT || act == ACT_ADD_BACK) val = rand_word();
        else if (act == ACT_REMOVE || act == ACT_FIND) val = pick_key();
        else val = word_t'($urandom);
        if (ph == PH_GROW && shadow_count[PLAN] == cnt_t'(CAPACITY)) edge_hits++;
        queue_request(act, val);
        if (ph == PH_DRAIN && shadow_count[PLAN] == '0) edge_hits++;
        rand_count++;
        span++;
        case (ph)
          PH_GROW:  phase_over = edge_hits >= 3 || span >= 150;
          PH_DRAIN: phase_over = edge_hits >= 3 || span >= 150;
          default:  phase_over = span >= mix_len;
        endcase
      end
      phase_idx++;
    end

    // wait until every transaction is in and every reply is out
    do @(negedge clk);
    while (accepted_count != planned_count || awaited_replies.size() != 0);
    repeat (CAPACITY + 4) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: hold reset, then present transactions in bursts with gaps
  always @(negedge clk) begin
    if (reset_left > 0) begin
      reset_left--;
      if (reset_left == 0) rst_n <= 1'b1;
    end else if (!start || took_item) begin
      if (gap_left > 0 || request_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start     <= 1'b0;
        in_action <= 4'($urandom);
        in_item   <= $urandom;
      end else begin
        next_req = request_queue.pop_front();
        start     <= 1'b1;
        in_action <= next_req.action;
        in_item   <= next_req.item;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor: check each reply against the oldest expectation, then predict
  always @(posedge clk) begin
    took_item <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected reply: data %h status %0d count %0d last %0b",
                 out_data, out_status, out_count, out_last);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_data !== want.data) begin
            $error("data: expected %h, got %h", want.data, out_data);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            error_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_request(TRACK, in_action, in_item);
        accepted_count++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
